// ----- rtl/tsfm_pkg.sv -----
// Package for the throttle sensor filter monitor.
// Holds field widths, codes, register indexes and the sequencer state type.
// No dependencies.
package tsfm_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COUNT_W   = 10;
    localparam int FAULT_W   = 2;
    localparam int POS_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int OUT_DAT_W = 32;

    // position divider: quotient never exceeds 100, so 7 quotient bits
    localparam int QUOT_W = 7;
    localparam int NUM_W  = SAMPLE_W + QUOT_W;

    localparam int FILTER_SHIFT = 8;

    localparam logic [SAMPLE_W-1:0] RAW_INVALID = 16'hFFFF;
    localparam logic [SAMPLE_W-1:0] HIGH_RESET  = 16'hFFFF;
    localparam logic [SAMPLE_W-1:0] LOW_RESET   = 16'h0000;

    localparam logic [POS_W-1:0] POS_EMPTY = 8'd0;
    localparam logic [POS_W-1:0] POS_FULL  = 8'd100;
    localparam logic [POS_W-1:0] POS_UNDEF = 8'hFF;

    localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_HIGH = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_LOW  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_CLASS,
        ST_DIV,
        ST_OUT
    } tsfm_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ----- rtl/tsfm_div.sv -----
// Bit-serial restoring divider for the position computation.
// One quotient bit per cycle; the quotient has QUOT_W bits.
// Depends on tsfm_pkg.
module tsfm_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [tsfm_pkg::NUM_W-1:0]     numerator,
    input  logic [tsfm_pkg::SAMPLE_W-1:0]  divisor,
    output tsfm_pkg::div_status_t          status,
    output logic [tsfm_pkg::QUOT_W-1:0]    quotient
);
    import tsfm_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [SAMPLE_W-1:0] rem_reg, rem_next;
    logic [SAMPLE_W-1:0] den_reg, den_next;
    logic [QUOT_W-1:0]   shq_reg, shq_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [SAMPLE_W:0]   trial;
    logic [SAMPLE_W:0]   diff;
    logic                fits;

    // numerator < 2^QUOT_W * divisor, so the top bits start below the divisor
    always_comb begin
        trial     = {rem_reg, shq_reg[QUOT_W-1]};
        diff      = trial - {1'b0, den_reg};
        fits      = (trial >= {1'b0, den_reg});
        rem_next  = rem_reg;
        den_next  = den_reg;
        shq_next  = shq_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = numerator[NUM_W-1:QUOT_W];
            shq_next  = numerator[QUOT_W-1:0];
            den_next  = divisor;
            cnt_next  = CNT_W'(QUOT_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
            shq_next = {shq_reg[QUOT_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        shq_reg <= shq_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = shq_reg;

    a_cnt_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cnt_reg != '0))
        else $error("divider busy with zero count");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

endmodule

// ----- rtl/throttle_sensor_filter_monitor.sv -----
// Throttle sensor filter monitor: moving average, fault classing, position.
// Top level with sequencer, state registers and output register.
// Depends on tsfm_pkg and tsfm_div.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata: raw_sample
//  m_       out  m_tvalid/m_tready  m_tdata: fault_code, filtered_level, position
//  cfg_     in   cfg_we             cfg_index, cfg_wdata
//
// The result register loads after the UPDATE, CLASS and OUT states, with DIV between
// CLASS and OUT when the position needs the divider (start, 7 quotient steps in
// tsfm_div, done); the next accept can follow in the cycle after the result loads.
// s_tready is high only in the idle state; the result waits in the output
// register while m_tready is low, and the next transaction may be accepted
// meanwhile. Synchronous active-low reset; sample, pos and tdata registers have none.
module throttle_sensor_filter_monitor #(
    parameter int STARTUP_IGNORE = 1000
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tsfm_pkg::SAMPLE_W-1:0]   s_tdata,  // [15:0] raw_sample
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tsfm_pkg::OUT_DAT_W-1:0]  m_tdata,  // [1:0] fault_code,
                                                      // [17:2] filtered_level,
                                                      // [25:18] position_percent
    input  logic                            cfg_we,
    input  logic [tsfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsfm_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
    import tsfm_pkg::*;

    localparam logic [COUNT_W-1:0] IGNORE_CNT = COUNT_W'(STARTUP_IGNORE);

    tsfm_state_t          state_reg, state_next;
    logic                 enable_reg;
    logic [SAMPLE_W-1:0]  high_reg;
    logic [SAMPLE_W-1:0]  low_reg;
    logic [SAMPLE_W-1:0]  sample_reg, sample_next;
    logic [SAMPLE_W-1:0]  average_reg, average_next;
    logic [FAULT_W-1:0]   fault_reg, fault_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_DAT_W-1:0] m_tdata_reg, m_tdata_next;

    logic signed [SAMPLE_W:0] delta;
    logic signed [SAMPLE_W:0] step;
    logic [SAMPLE_W-1:0]      span;
    logic [NUM_W-1:0]         scaled;
    logic                     above;
    logic                     below;
    logic                     div_start;
    div_status_t              div_stat;
    logic [QUOT_W-1:0]        div_quot;

    tsfm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .numerator (scaled),
        .divisor   (high_reg - low_reg),
        .status    (div_stat),
        .quotient  (div_quot)
    );

    always_comb begin
        delta  = $signed({1'b0, sample_reg}) - $signed({1'b0, average_reg});
        step   = delta >>> FILTER_SHIFT;
        above  = (average_reg > high_reg);
        below  = (average_reg < low_reg);
        span   = average_reg - low_reg;
        // span * 100
        scaled = (NUM_W'(span) << 6) + (NUM_W'(span) << 5) + (NUM_W'(span) << 2);
    end

    always_comb begin
        state_next    = state_reg;
        sample_next   = sample_reg;
        average_next  = average_reg;
        fault_next    = fault_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        div_start     = 1'b0;
        s_tready      = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    sample_next = s_tdata;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (enable_reg && (sample_reg != RAW_INVALID)) begin
                    average_next = average_reg + step[SAMPLE_W-1:0];
                end
                state_next = ST_CLASS;
            end
            ST_CLASS: begin
                if (enable_reg) begin
                    if (count_reg < IGNORE_CNT) begin
                        count_next = count_reg + COUNT_W'(1);
                        fault_next = FAULT_NONE;
                    end else if (above) begin
                        fault_next = FAULT_HIGH;
                    end else if (below) begin
                        fault_next = FAULT_LOW;
                    end else begin
                        fault_next = FAULT_NONE;
                    end
                end
                state_next = ST_OUT;
                if (below) begin
                    pos_next = POS_EMPTY;
                end else if (above) begin
                    pos_next = POS_FULL;
                end else if (high_reg == low_reg) begin
                    pos_next = POS_UNDEF;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    pos_next   = POS_W'(div_quot);
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_DAT_W'({pos_reg, average_reg, fault_reg});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            enable_reg   <= 1'b0;
            high_reg     <= HIGH_RESET;
            low_reg      <= LOW_RESET;
            average_reg  <= '0;
            fault_reg    <= FAULT_NONE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            average_reg  <= average_next;
            fault_reg    <= fault_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SENSOR_EN: enable_reg <= cfg_wdata[0];
                    CFG_HIGH_THR:  high_reg   <= cfg_wdata;
                    CFG_LOW_THR:   low_reg    <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg  <= sample_next;
        pos_reg     <= pos_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted a transaction while busy");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg <= IGNORE_CNT) || (count_reg == $past(count_reg)))
        else $error("startup count ran past its limit");
    a_fault_code: assert property (@(posedge aclk) disable iff (!aresetn)
        fault_reg != 2'd3)
        else $error("illegal fault code stored");
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> ((m_tdata_reg[25:18] <= POS_FULL) ||
                          (m_tdata_reg[25:18] == POS_UNDEF)))
        else $error("position out of range");
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

endmodule

// ----- bench/throttle_sensor_filter_monitor_tb.sv -----
// Self-checking testbench for throttle_sensor_filter_monitor: a stream driver, a
// result monitor and a bit-accurate predictor of average, fault and position.
// Depends on tsfm_pkg and the RTL of the block.
`timescale 1ns / 1ps

module throttle_sensor_filter_monitor_tb;
    import tsfm_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 5;
    localparam int STARTUP_IGNORE = 1000;
    localparam int IDLE_PCT       = 18;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PHASES         = 16;
    localparam int PHASE_ITEMS    = 80;
    localparam int MAX_REPORTS    = 100;
    localparam int PERCENT_SCALE  = 100;
    localparam time TIMEOUT_NS    = 10_000_000;

    typedef struct packed {
        logic [FAULT_W-1:0]  fault;
        logic [SAMPLE_W-1:0] level;
        logic [POS_W-1:0]    pos;
    } reading_t;

    typedef enum int {
        THR_FULL,
        THR_EQUAL,
        THR_CROSSED,
        THR_STRADDLE,
        THR_RANDOM,
        THR_ZERO
    } thr_plan_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DAT_W-1:0]  m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_wdata = '0;

    logic                  steady = 1'b0;
    logic                  long_hold_req = 1'b0;
    logic                  hold_done = 1'b0;
    int                    hold_cycles = 0;
    int                    mismatch_count = 0;

    logic [SAMPLE_W-1:0]   pending_samples[$];
    reading_t              expected_readings[$];

    // predictor state and register copies
    logic                  en_cfg = 1'b0;
    logic [SAMPLE_W-1:0]   high_thr = HIGH_RESET;
    logic [SAMPLE_W-1:0]   low_thr = LOW_RESET;
    logic [SAMPLE_W-1:0]   avg_level = '0;
    logic [FAULT_W-1:0]    stored_fault = FAULT_NONE;
    logic [COUNT_W-1:0]    warmup_count = '0;

    throttle_sensor_filter_monitor #(
        .STARTUP_IGNORE(STARTUP_IGNORE)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [15:0] raw_sample
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [1:0] fault, [17:2] level, [25:18] position
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic reading_t track_sample(input logic [SAMPLE_W-1:0] raw);
        logic signed [SAMPLE_W:0] diff;
        reading_t r;
        if (en_cfg) begin
            if (raw != RAW_INVALID) begin
                diff = $signed({1'b0, raw}) - $signed({1'b0, avg_level});
                avg_level = avg_level + SAMPLE_W'(diff >>> FILTER_SHIFT);
            end
            if (warmup_count < STARTUP_IGNORE) begin
                warmup_count = warmup_count + 1'b1;
                stored_fault = FAULT_NONE;
            end else if (avg_level > high_thr) begin
                stored_fault = FAULT_HIGH;
            end else if (avg_level < low_thr) begin
                stored_fault = FAULT_LOW;
            end else begin
                stored_fault = FAULT_NONE;
            end
        end
        r.fault = stored_fault;
        r.level = avg_level;
        if (avg_level < low_thr) begin
            r.pos = POS_EMPTY;
        end else if (avg_level > high_thr) begin
            r.pos = POS_FULL;
        end else if (high_thr == low_thr) begin
            r.pos = POS_UNDEF;
        end else begin
            r.pos = POS_W'((32'(avg_level - low_thr) * PERCENT_SCALE)
                           / 32'(high_thr - low_thr));
        end
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] aim);
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 6) begin
            return RAW_INVALID;
        end else if (r < 40) begin
            return SAMPLE_W'($urandom_range(0, 65535));
        end
        v = int'(aim) + $urandom_range(0, 1023) - 512;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return SAMPLE_W'(v);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_SENSOR_EN: en_cfg = val[0];
            CFG_HIGH_THR:  high_thr = val;
            CFG_LOW_THR:   low_thr = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // checked at the falling edge so the driver's updates have settled
    task automatic drain();
        do @(negedge aclk);
        while (pending_samples.size() != 0 || s_tvalid || expected_readings.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_thresholds(input thr_plan_t plan);
        logic [SAMPLE_W-1:0] hi;
        logic [SAMPLE_W-1:0] lo;
        int d;
        case (plan)
            THR_FULL: begin
                hi = HIGH_RESET;
                lo = LOW_RESET;
            end
            THR_EQUAL: begin
                hi = avg_level;
                lo = avg_level;
            end
            THR_CROSSED: begin
                lo = SAMPLE_W'($urandom_range(32768, 65535));
                hi = SAMPLE_W'($urandom_range(0, 32767));
            end
            THR_STRADDLE: begin
                d = $urandom_range(1, 2000);
                hi = (int'(avg_level) + d > 65535) ? 16'hFFFF : avg_level + SAMPLE_W'(d);
                d = $urandom_range(0, 2000);
                lo = (int'(avg_level) < d) ? 16'h0000 : avg_level - SAMPLE_W'(d);
            end
            THR_RANDOM: begin
                hi = SAMPLE_W'($urandom_range(0, 65535));
                lo = SAMPLE_W'($urandom_range(0, 65535));
            end
            default: begin
                hi = '0;
                lo = '0;
            end
        endcase
        write_reg(CFG_HIGH_THR, hi);
        write_reg(CFG_LOW_THR, lo);
    endtask

    // stimulus
    initial begin
        thr_plan_t plan;
        logic [SAMPLE_W-1:0] aim;
        int n;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // sensor disabled: state frozen
        pending_samples = '{16'h0000, RAW_INVALID, 16'h8000, 16'h7FFF};
        drain();
        write_reg(CFG_SENSOR_EN, CFG_DAT_W'(1));
        pending_samples = '{RAW_INVALID, 16'hFFFE, 16'hFFFE, 16'h0000,
                            16'h5555, 16'hAAAA, 16'h0001, 16'h8000};
        drain();
        // equal thresholds at the current average
        set_thresholds(THR_EQUAL);
        pending_samples = '{RAW_INVALID, RAW_INVALID, 16'hFFFE, 16'h0000};
        drain();
        write_reg(CFG_HIGH_THR, 16'h1000);
        write_reg(CFG_LOW_THR, 16'h9000);
        pending_samples = '{16'h1234, 16'hFEDC};
        drain();
        write_reg(CFG_HIGH_THR, 16'hFFFF);
        write_reg(CFG_LOW_THR, 16'hFFFF);
        pending_samples = '{16'h0000, RAW_INVALID};
        drain();
        set_thresholds(THR_ZERO);
        pending_samples = '{16'h4000, 16'h0000};
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(CFG_SENSOR_EN, CFG_DAT_W'(ph != 14));
            plan = (ph >= 12 && ph != 14) ? THR_STRADDLE : thr_plan_t'(ph % 6);
            set_thresholds(plan);
            aim = SAMPLE_W'($urandom_range(0, 65535));
            if (plan == THR_STRADDLE)
                aim = ($urandom_range(1)) ? 16'hFFFE : 16'h0000;
            n = (ph == 14) ? 30 : PHASE_ITEMS;
            steady <= (ph == 5);
            for (int i = 0; i < n; i++) begin
                if (ph == 9 && i == n / 2)
                    drain();
                if (plan == THR_STRADDLE && i == n / 2)
                    aim = ~aim - 1'b1;
                pending_samples.push_back(pick_sample(aim));
            end
            if (ph == 7)
                long_hold_req <= 1'b1;
            drain();
        end
        steady <= 1'b0;

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    // input driver; predicts on each accepted transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_readings.push_back(track_sample(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (pending_samples.size() != 0 &&
                    (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    s_tdata <= pending_samples.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result ready, with one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (long_hold_req && !hold_done) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_readings.size() == 0) begin
                report_mismatch("unexpected transaction", int'(m_tdata), 0);
            end else begin
                want = expected_readings.pop_front();
                if (m_tdata[1:0] != want.fault)
                    report_mismatch("fault_code", int'(m_tdata[1:0]), int'(want.fault));
                if (m_tdata[17:2] != want.level)
                    report_mismatch("filtered_level", int'(m_tdata[17:2]),
                                    int'(want.level));
                if (m_tdata[25:18] != want.pos)
                    report_mismatch("position_percent", int'(m_tdata[25:18]),
                                    int'(want.pos));
                if (m_tdata[31:26] != '0)
                    report_mismatch("tdata padding", int'(m_tdata[31:26]), 0);
            end
        end
    end

endmodule
